// File: rtl/stqd_pkg.sv
// ----------------------------------------------------------------------------
// stqd_pkg
// Shared types and codes of the serial transmit queue dispatcher.
// ----------------------------------------------------------------------------
package stqd_pkg;

	// operation codes of an input item
	localparam logic [1:0] OP_ENQUEUE  = 2'd0;
	localparam logic [1:0] OP_UART_DONE = 2'd1;
	localparam logic [1:0] OP_SPI_DONE  = 2'd2;
	localparam logic [1:0] OP_I2C_EVENT = 2'd3;

	// link codes of an entry
	localparam logic [1:0] LINK_UART = 2'd0;
	localparam logic [1:0] LINK_SPI  = 2'd1;
	localparam logic [1:0] LINK_I2C  = 2'd2;

	// ring and channel indexes
	localparam logic [1:0] RING_GENERAL = 2'd0;
	localparam logic [1:0] RING_UART    = 2'd1;
	localparam logic [1:0] RING_SPI     = 2'd2;
	localparam logic [1:0] RING_I2C     = 2'd3;

	// result actions
	localparam logic [2:0] ACT_UART_SEND = 3'd0;
	localparam logic [2:0] ACT_SPI_SEND  = 3'd1;
	localparam logic [2:0] ACT_I2C_START = 3'd2;
	localparam logic [2:0] ACT_I2C_ADDR  = 3'd3;
	localparam logic [2:0] ACT_I2C_BYTE  = 3'd4;
	localparam logic [2:0] ACT_I2C_STOP  = 3'd5;
	localparam logic [2:0] ACT_NOTIFY    = 3'd6;
	localparam logic [2:0] ACT_DROPPED   = 3'd7;

	typedef enum logic [1:0] {
		SLOT_FREE = 2'd0,
		SLOT_WAIT = 2'd1,
		SLOT_SEND = 2'd2
	} slot_stat_t;

	typedef enum logic [1:0] {
		PH_ADDR = 2'd0,
		PH_BODY = 2'd1,
		PH_STOP = 2'd2
	} i2c_phase_t;

	typedef struct packed {
		logic [1:0] link;
		logic [7:0] data;
		logic [7:0] slave;
		logic [7:0] regaddr;
		logic       reg_avail;
		logic       notify_en;
		logic [7:0] tag;
	} slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OP,
		ST_NOTE,
		ST_SETTLE,
		ST_DISP,
		ST_FLUSH
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic       accept;
		logic       op;
		logic       note;
		logic       disp;
		logic [1:0] ring;
		logic       flush;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_note;
	} sts_t;

endpackage

// File: rtl/stqd_ring.sv
// ----------------------------------------------------------------------------
// stqd_ring
// One transmit ring: slot status flops, read and write pointers, entry memory.
// ----------------------------------------------------------------------------
module stqd_ring #(
	parameter int DEPTH = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  stqd_pkg::slot_t wr_data,
	input  logic            send_head,
	input  logic            free_head,
	output logic            wr_free,
	output stqd_pkg::slot_stat_t head_stat,
	output stqd_pkg::slot_t head_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

	stqd_pkg::slot_stat_t stat_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	stqd_pkg::slot_t mem [DEPTH];
	stqd_pkg::slot_t rd_data_q;

	assign wr_free   = (stat_q[wr_ptr_q] == stqd_pkg::SLOT_FREE);
	assign head_stat = stat_q[rd_ptr_q];
	assign head_data = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) stat_q[i] <= stqd_pkg::SLOT_FREE;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en) begin
				stat_q[wr_ptr_q] <= stqd_pkg::SLOT_WAIT;
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (send_head) stat_q[rd_ptr_q] <= stqd_pkg::SLOT_SEND;
			if (free_head) begin
				stat_q[rd_ptr_q] <= stqd_pkg::SLOT_FREE;
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_ptr_q] <= wr_data;
		rd_data_q <= mem[rd_ptr_q];
	end

endmodule

// File: rtl/stqd_datapath.sv
// ----------------------------------------------------------------------------
// stqd_datapath
// Rings, channel busy flags, i2c phase and the result register pair.
// ----------------------------------------------------------------------------
module stqd_datapath #(
	parameter int GENERAL_DEPTH = 8,
	parameter int UART_DEPTH    = 8,
	parameter int SPI_DEPTH     = 8,
	parameter int I2C_DEPTH     = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  stqd_pkg::cmd_t cmd,
	output stqd_pkg::sts_t sts,
	input  logic [1:0]     operation,
	input  logic [7:0]     payload_byte,
	input  logic [1:0]     target_link,
	input  logic           use_general,
	input  logic           has_slave,
	input  logic [7:0]     slave_address,
	input  logic           has_register,
	input  logic [7:0]     register_address,
	input  logic           notify_enable,
	input  logic [7:0]     notify_tag,
	output logic           strobe,
	output logic [2:0]     action,
	output logic [7:0]     out_byte,
	output logic [7:0]     done_tag,
	output logic           last
);

	// latched item
	logic [1:0]      op_q;
	logic [7:0]      byte_q;
	logic [1:0]      link_q;
	logic            gen_q;
	stqd_pkg::slot_t new_slot_q;

	logic [3:0]           busy_q;
	stqd_pkg::i2c_phase_t phase_q;
	logic                 reg_done_q;
	logic [1:0]           owner_q;
	logic [1:0]           ch_q;

	logic                 pend_v_q;
	logic [2:0]           pend_act_q;
	logic [7:0]           pend_byte_q;
	logic [7:0]           pend_tag_q;

	logic                 wr_en [4];
	logic                 send_head [4];
	logic                 free_head [4];
	logic                 wr_free [4];
	stqd_pkg::slot_stat_t head_stat [4];
	stqd_pkg::slot_t      head_data [4];

	logic [1:0] enq_ring;
	logic       enq_drop;
	logic       own_ded;
	logic       own_gen;
	logic       owner_ok;
	logic [1:0] owner;
	stqd_pkg::slot_t own_slot;
	stqd_pkg::slot_t note_slot;
	stqd_pkg::slot_t disp_slot;
	logic       disp_go;
	logic [1:0] disp_ch;

	logic       res_v;
	logic [2:0] res_act;
	logic [7:0] res_byte;
	logic [7:0] res_tag;

	stqd_ring #(.DEPTH(GENERAL_DEPTH)) u_ring_gen (
		.clk, .arst_n, .wr_en(wr_en[0]), .wr_data(new_slot_q),
		.send_head(send_head[0]), .free_head(free_head[0]), .wr_free(wr_free[0]),
		.head_stat(head_stat[0]), .head_data(head_data[0]));
	stqd_ring #(.DEPTH(UART_DEPTH)) u_ring_uart (
		.clk, .arst_n, .wr_en(wr_en[1]), .wr_data(new_slot_q),
		.send_head(send_head[1]), .free_head(free_head[1]), .wr_free(wr_free[1]),
		.head_stat(head_stat[1]), .head_data(head_data[1]));
	stqd_ring #(.DEPTH(SPI_DEPTH)) u_ring_spi (
		.clk, .arst_n, .wr_en(wr_en[2]), .wr_data(new_slot_q),
		.send_head(send_head[2]), .free_head(free_head[2]), .wr_free(wr_free[2]),
		.head_stat(head_stat[2]), .head_data(head_data[2]));
	stqd_ring #(.DEPTH(I2C_DEPTH)) u_ring_i2c (
		.clk, .arst_n, .wr_en(wr_en[3]), .wr_data(new_slot_q),
		.send_head(send_head[3]), .free_head(free_head[3]), .wr_free(wr_free[3]),
		.head_stat(head_stat[3]), .head_data(head_data[3]));

	always_comb begin
		enq_ring = gen_q ? stqd_pkg::RING_GENERAL : link_q + 2'd1;
		enq_drop = (link_q == 2'd3) || !wr_free[enq_ring];
		// operation code doubles as the channel index for done and i2c events
		own_ded  = (head_stat[op_q] == stqd_pkg::SLOT_SEND);
		own_gen  = busy_q[0] && (head_stat[0] == stqd_pkg::SLOT_SEND)
			&& (head_data[0].link == op_q - 2'd1);
		owner_ok = busy_q[op_q] && (own_ded || own_gen);
		owner    = own_ded ? op_q : stqd_pkg::RING_GENERAL;
		own_slot = head_data[owner];
		note_slot = head_data[owner_q];
		disp_slot = head_data[cmd.ring];
		disp_ch  = disp_slot.link + 2'd1;
		disp_go  = !busy_q[cmd.ring] && (head_stat[cmd.ring] == stqd_pkg::SLOT_WAIT)
			&& (disp_slot.link != 2'd3) && !busy_q[disp_ch];
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			wr_en[r]     = cmd.op && (op_q == stqd_pkg::OP_ENQUEUE) && !enq_drop
				&& (enq_ring == 2'(r));
			send_head[r] = cmd.disp && disp_go && (cmd.ring == 2'(r));
			free_head[r] = cmd.note && (owner_q == 2'(r));
		end
	end

	// one result at most per step
	always_comb begin
		res_v         = 1'b0;
		res_act       = stqd_pkg::ACT_DROPPED;
		res_byte      = '0;
		res_tag       = '0;
		sts.need_note = 1'b0;
		if (cmd.op) begin
			unique case (op_q)
				stqd_pkg::OP_ENQUEUE: begin
					if (enq_drop) begin
						res_v    = 1'b1;
						res_act  = stqd_pkg::ACT_DROPPED;
						res_byte = byte_q;
					end
				end
				stqd_pkg::OP_UART_DONE, stqd_pkg::OP_SPI_DONE: begin
					sts.need_note = owner_ok;
				end
				default: begin
					if (owner_ok) begin
						res_v = 1'b1;
						unique case (phase_q)
							stqd_pkg::PH_BODY: begin
								res_act  = stqd_pkg::ACT_I2C_BYTE;
								res_byte = (own_slot.reg_avail && !reg_done_q)
									? own_slot.regaddr : own_slot.data;
							end
							stqd_pkg::PH_STOP: begin
								res_act       = stqd_pkg::ACT_I2C_STOP;
								sts.need_note = 1'b1;
							end
							default: begin
								res_act  = stqd_pkg::ACT_I2C_ADDR;
								res_byte = own_slot.slave;
							end
						endcase
					end
				end
			endcase
		end else if (cmd.note) begin
			if (note_slot.notify_en) begin
				res_v   = 1'b1;
				res_act = stqd_pkg::ACT_NOTIFY;
				res_tag = note_slot.tag;
			end
		end else if (cmd.disp && disp_go) begin
			res_v = 1'b1;
			unique case (disp_slot.link)
				stqd_pkg::LINK_UART: begin
					res_act  = stqd_pkg::ACT_UART_SEND;
					res_byte = disp_slot.data;
				end
				stqd_pkg::LINK_SPI: begin
					res_act  = stqd_pkg::ACT_SPI_SEND;
					res_byte = disp_slot.data;
				end
				default: res_act = stqd_pkg::ACT_I2C_START;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= operation;
			byte_q <= payload_byte;
			link_q <= target_link;
			gen_q  <= use_general;
			new_slot_q.link      <= target_link;
			new_slot_q.data      <= payload_byte;
			new_slot_q.slave     <= has_slave ? slave_address : 8'd0;
			new_slot_q.regaddr   <= has_slave ? register_address : 8'd0;
			new_slot_q.reg_avail <= has_slave & has_register;
			new_slot_q.notify_en <= notify_enable;
			new_slot_q.tag       <= notify_tag;
		end
		if (cmd.op) begin
			owner_q <= owner;
			ch_q    <= op_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= '0;
			phase_q    <= stqd_pkg::PH_ADDR;
			reg_done_q <= 1'b0;
		end else begin
			if (cmd.op && (op_q == stqd_pkg::OP_I2C_EVENT) && owner_ok) begin
				unique case (phase_q)
					stqd_pkg::PH_BODY: begin
						if (own_slot.reg_avail && !reg_done_q) reg_done_q <= 1'b1;
						else phase_q <= stqd_pkg::PH_STOP;
					end
					stqd_pkg::PH_STOP: phase_q <= stqd_pkg::PH_ADDR;
					default: begin
						phase_q    <= stqd_pkg::PH_BODY;
						reg_done_q <= 1'b0;
					end
				endcase
			end
			if (cmd.note) begin
				busy_q[owner_q] <= 1'b0;
				busy_q[ch_q]    <= 1'b0;
			end
			if (cmd.disp && disp_go) begin
				busy_q[cmd.ring] <= 1'b1;
				busy_q[disp_ch]  <= 1'b1;
			end
		end
	end

	// hold one result back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (res_v) begin
				pend_v_q <= 1'b1;
				strobe   <= pend_v_q;
			end else if (cmd.flush && pend_v_q) begin
				pend_v_q <= 1'b0;
				strobe   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_v) begin
			pend_act_q  <= res_act;
			pend_byte_q <= res_byte;
			pend_tag_q  <= res_tag;
		end
		if ((res_v && pend_v_q) || (cmd.flush && pend_v_q)) begin
			action   <= pend_act_q;
			out_byte <= pend_byte_q;
			done_tag <= pend_tag_q;
			last     <= !res_v;
		end
	end

endmodule

// File: rtl/stqd_ctrl.sv
// ----------------------------------------------------------------------------
// stqd_ctrl
// Sequencer: event step, completion step, settle step, four dispatch steps, flush.
// ----------------------------------------------------------------------------
module stqd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  stqd_pkg::sts_t sts,
	output stqd_pkg::cmd_t cmd
);

	stqd_pkg::ctl_state_t state_q, state_d;
	logic [1:0] ring_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stqd_pkg::ST_IDLE;
			ring_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == stqd_pkg::ST_DISP) ring_q <= ring_q + 2'd1;
			else ring_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stqd_pkg::ST_IDLE:   if (start) state_d = stqd_pkg::ST_OP;
			stqd_pkg::ST_OP:     state_d = sts.need_note ? stqd_pkg::ST_NOTE
				: stqd_pkg::ST_SETTLE;
			stqd_pkg::ST_NOTE:   state_d = stqd_pkg::ST_SETTLE;
			stqd_pkg::ST_SETTLE: state_d = stqd_pkg::ST_DISP;
			stqd_pkg::ST_DISP:   if (ring_q == 2'd3) state_d = stqd_pkg::ST_FLUSH;
			stqd_pkg::ST_FLUSH:  state_d = stqd_pkg::ST_IDLE;
			default:             state_d = stqd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy       = (state_q != stqd_pkg::ST_IDLE);
		cmd.accept = start && (state_q == stqd_pkg::ST_IDLE);
		cmd.op     = (state_q == stqd_pkg::ST_OP);
		cmd.note   = (state_q == stqd_pkg::ST_NOTE);
		cmd.disp   = (state_q == stqd_pkg::ST_DISP);
		cmd.ring   = ring_q;
		cmd.flush  = (state_q == stqd_pkg::ST_FLUSH);
	end

endmodule

// File: rtl/serial_transmit_queue_dispatcher_core.sv
// ----------------------------------------------------------------------------
// serial_transmit_queue_dispatcher_core
// Four transmit rings dispatched onto uart, spi and i2c links.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low. It runs one event step,
// a completion step only when it completes an entry (done event or i2c stop),
// a settle step for the ring memory read, one dispatch step per ring and a
// flush step. Up to five results follow, one cycle each, marked by strobe;
// the last one carries last and may show in the first idle cycle. Results
// cannot be held off.
module serial_transmit_queue_dispatcher_core #(
	parameter int GENERAL_DEPTH = 8,
	parameter int UART_DEPTH    = 8,
	parameter int SPI_DEPTH     = 8,
	parameter int I2C_DEPTH     = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] operation,
	input  logic [7:0] payload_byte,
	input  logic [1:0] target_link,
	input  logic       use_general,
	input  logic       has_slave,
	input  logic [7:0] slave_address,
	input  logic       has_register,
	input  logic [7:0] register_address,
	input  logic       notify_enable,
	input  logic [7:0] notify_tag,
	output logic       strobe,
	output logic [2:0] action,
	output logic [7:0] out_byte,
	output logic [7:0] done_tag,
	output logic       last
);

	stqd_pkg::cmd_t cmd;
	stqd_pkg::sts_t sts;

	stqd_ctrl u_ctrl (
		.clk, .arst_n, .start, .busy, .sts, .cmd);

	stqd_datapath #(
		.GENERAL_DEPTH(GENERAL_DEPTH), .UART_DEPTH(UART_DEPTH),
		.SPI_DEPTH(SPI_DEPTH), .I2C_DEPTH(I2C_DEPTH)
	) u_dp (
		.clk, .arst_n, .cmd, .sts, .operation, .payload_byte, .target_link,
		.use_general, .has_slave, .slave_address, .has_register, .register_address,
		.notify_enable, .notify_tag, .strobe, .action, .out_byte, .done_tag, .last);

endmodule

// File: rtl/stqd_checker.sv
// ----------------------------------------------------------------------------
// stqd_checker
// Port level checks of the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module stqd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [2:0] action,
	input logic [7:0] done_tag,
	input logic       last
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item taken but block not busy");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result right after final result");

	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !busy |-> last)
		else $error("non-final result while idle");

	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (action != stqd_pkg::ACT_NOTIFY) |-> (done_tag == 8'd0))
		else $error("tag on a non-notify result");

endmodule

bind serial_transmit_queue_dispatcher_core stqd_checker u_stqd_checker (
	.clk, .arst_n, .start, .busy, .strobe, .action, .done_tag, .last);

// File: tb/serial_transmit_queue_dispatcher_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_transmit_queue_dispatcher_core_test
// Drives enqueue, byte done and i2c bus events into the dispatcher, predicts
// the sends, i2c phases, notifies and drops, and checks every result.
// ----------------------------------------------------------------------------
module serial_transmit_queue_dispatcher_core_test;

	localparam int DEPTH = 8;
	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		logic [1:0] op;
		logic [7:0] data;
		logic [1:0] link;
		logic       gen;
		logic       hs;
		logic [7:0] slv;
		logic       hr;
		logic [7:0] rg;
		logic       ne;
		logic [7:0] tg;
	} cmd_item_t;

	typedef struct {
		logic [2:0] act;
		logic [7:0] byt;
		logic [7:0] tag;
		logic       lst;
	} tx_result_t;

	typedef struct {
		stqd_pkg::slot_stat_t st;
		stqd_pkg::slot_t      s;
	} entry_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] operation = '0;
	logic [7:0] payload_byte = '0;
	logic [1:0] target_link = '0;
	logic       use_general = 1'b0;
	logic       has_slave = 1'b0;
	logic [7:0] slave_address = '0;
	logic       has_register = 1'b0;
	logic [7:0] register_address = '0;
	logic       notify_enable = 1'b0;
	logic [7:0] notify_tag = '0;
	logic       strobe;
	logic [2:0] action;
	logic [7:0] out_byte;
	logic [7:0] done_tag;
	logic       last;

	serial_transmit_queue_dispatcher_core dut (.*);

	always #10 clk = ~clk;

	// predictor state
	entry_t               rings [4][DEPTH];
	int                   wptr [4];
	int                   rptr [4];
	bit                   chan_busy [4];
	stqd_pkg::i2c_phase_t phase;

	tx_result_t pending_results [$];
	tx_result_t step_out [$];
	int         mismatches = 0;
	int         accepted_items = 0;
	int         checked_results = 0;
	int         idle_cycles = 0;
	bit         timed_out = 0;

	function automatic int next_ptr(int p);
		return (p + 1 >= DEPTH) ? 0 : p + 1;
	endfunction

	function automatic void put_result(logic [2:0] a, logic [7:0] b, logic [7:0] t);
		tx_result_t r;
		r.act = a;
		r.byt = b;
		r.tag = t;
		r.lst = 1'b0;
		if (step_out.size() < 5)
			step_out.push_back(r);
	endfunction

	function automatic void start_head(int r);
		int ch;
		if (chan_busy[r])
			return;
		if (rings[r][rptr[r]].st != stqd_pkg::SLOT_WAIT
				|| rings[r][rptr[r]].s.link > stqd_pkg::LINK_I2C)
			return;
		ch = 1 + rings[r][rptr[r]].s.link;
		if (chan_busy[ch])
			return;
		chan_busy[ch] = 1;
		chan_busy[r] = 1;
		rings[r][rptr[r]].st = stqd_pkg::SLOT_SEND;
		case (rings[r][rptr[r]].s.link)
			stqd_pkg::LINK_UART:
				put_result(stqd_pkg::ACT_UART_SEND, rings[r][rptr[r]].s.data, 8'd0);
			stqd_pkg::LINK_SPI:
				put_result(stqd_pkg::ACT_SPI_SEND, rings[r][rptr[r]].s.data, 8'd0);
			default:
				put_result(stqd_pkg::ACT_I2C_START, 8'd0, 8'd0);
		endcase
	endfunction

	// ring that owns a channel, or -1
	function automatic int link_owner(int ch);
		if (rings[ch][rptr[ch]].st == stqd_pkg::SLOT_SEND)
			return ch;
		if (chan_busy[stqd_pkg::RING_GENERAL] && rings[0][rptr[0]].st == stqd_pkg::SLOT_SEND
				&& rings[0][rptr[0]].s.link == ch - 1)
			return stqd_pkg::RING_GENERAL;
		return -1;
	endfunction

	function automatic void retire(int r, int ch);
		rings[r][rptr[r]].st = stqd_pkg::SLOT_FREE;
		if (rings[r][rptr[r]].s.notify_en)
			put_result(stqd_pkg::ACT_NOTIFY, 8'd0, rings[r][rptr[r]].s.tag);
		rptr[r] = next_ptr(rptr[r]);
		chan_busy[r] = 0;
		chan_busy[ch] = 0;
	endfunction

	function automatic void predict_dispatch(cmd_item_t it);
		int r;
		int o;
		step_out.delete();
		case (it.op)
			stqd_pkg::OP_ENQUEUE: begin
				if (it.link > stqd_pkg::LINK_I2C) begin
					put_result(stqd_pkg::ACT_DROPPED, it.data, 8'd0);
				end else begin
					r = it.gen ? int'(stqd_pkg::RING_GENERAL) : 1 + it.link;
					if (rings[r][wptr[r]].st != stqd_pkg::SLOT_FREE) begin
						put_result(stqd_pkg::ACT_DROPPED, it.data, 8'd0);
					end else begin
						rings[r][wptr[r]].s.link = it.link;
						rings[r][wptr[r]].s.data = it.data;
						rings[r][wptr[r]].s.slave = it.hs ? it.slv : 8'd0;
						rings[r][wptr[r]].s.reg_avail = it.hs ? it.hr : 1'b0;
						rings[r][wptr[r]].s.regaddr = it.hs ? it.rg : 8'd0;
						rings[r][wptr[r]].s.notify_en = it.ne;
						rings[r][wptr[r]].s.tag = it.tg;
						rings[r][wptr[r]].st = stqd_pkg::SLOT_WAIT;
						wptr[r] = next_ptr(wptr[r]);
					end
				end
			end
			stqd_pkg::OP_UART_DONE, stqd_pkg::OP_SPI_DONE: begin
				r = int'(it.op);
				if (chan_busy[r]) begin
					o = link_owner(r);
					if (o >= 0)
						retire(o, r);
				end
			end
			default: begin
				if (chan_busy[stqd_pkg::RING_I2C]) begin
					o = link_owner(stqd_pkg::RING_I2C);
					if (o >= 0) begin
						if (phase == stqd_pkg::PH_BODY) begin
							if (rings[o][rptr[o]].s.reg_avail) begin
								rings[o][rptr[o]].s.reg_avail = 1'b0;
								put_result(stqd_pkg::ACT_I2C_BYTE,
									rings[o][rptr[o]].s.regaddr, 8'd0);
							end else begin
								phase = stqd_pkg::PH_STOP;
								put_result(stqd_pkg::ACT_I2C_BYTE,
									rings[o][rptr[o]].s.data, 8'd0);
							end
						end else if (phase == stqd_pkg::PH_STOP) begin
							phase = stqd_pkg::PH_ADDR;
							put_result(stqd_pkg::ACT_I2C_STOP, 8'd0, 8'd0);
							retire(o, stqd_pkg::RING_I2C);
						end else begin
							phase = stqd_pkg::PH_BODY;
							put_result(stqd_pkg::ACT_I2C_ADDR,
								rings[o][rptr[o]].s.slave, 8'd0);
						end
					end
				end
			end
		endcase
		for (r = 0; r < 4; r++)
			start_head(r);
		if (step_out.size() > 0)
			step_out[step_out.size() - 1].lst = 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		mismatches++;
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// result checker
	always @(posedge clk) begin
		tx_result_t e;
		if (arst_n && strobe) begin
			checked_results++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, action", {5'd0, action}, 8'd0);
			end else begin
				e = pending_results.pop_front();
				if (action !== e.act)
					report_mismatch("action", {5'd0, action}, {5'd0, e.act});
				if (out_byte !== e.byt)
					report_mismatch("out_byte", out_byte, e.byt);
				if (done_tag !== e.tag)
					report_mismatch("done_tag", done_tag, e.tag);
				if (last !== e.lst)
					report_mismatch("last", {7'd0, last}, {7'd0, e.lst});
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("watchdog expired after %0d quiet cycles", IDLE_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// row with an optional typed-in expectation
	typedef struct {
		cmd_item_t  it;
		bit         typed;
		tx_result_t want;
	} row_t;

	row_t rows [$];

	// start stays high across a zero gap so items can follow directly
	task automatic send_item(cmd_item_t it, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= it.op;
		payload_byte <= it.data;
		target_link <= it.link;
		use_general <= it.gen;
		has_slave <= it.hs;
		slave_address <= it.slv;
		has_register <= it.hr;
		register_address <= it.rg;
		notify_enable <= it.ne;
		notify_tag <= it.tg;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		accepted_items++;
		predict_dispatch(it);
		foreach (step_out[i])
			pending_results.push_back(step_out[i]);
	endtask

	function automatic cmd_item_t mk(logic [1:0] op, logic [7:0] d, logic [1:0] l, logic g,
			logic hs, logic [7:0] sl, logic hr, logic [7:0] rg, logic ne, logic [7:0] tg);
		cmd_item_t c;
		c.op = op; c.data = d; c.link = l; c.gen = g; c.hs = hs;
		c.slv = sl; c.hr = hr; c.rg = rg; c.ne = ne; c.tg = tg;
		return c;
	endfunction

	function automatic void add_row(cmd_item_t c, bit typed, logic [2:0] a, logic [7:0] b,
			logic [7:0] t);
		row_t r;
		r.it = c;
		r.typed = typed;
		r.want.act = a;
		r.want.byt = b;
		r.want.tag = t;
		r.want.lst = 1'b1;
		rows.push_back(r);
	endfunction

	function automatic cmd_item_t rand_enqueue();
		return mk(stqd_pkg::OP_ENQUEUE, 8'($urandom_range(0, 255)),
			($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
			$urandom_range(0, 3) == 0, $urandom_range(0, 1) == 1,
			8'($urandom_range(0, 255)),
			$urandom_range(0, 1) == 1, 8'($urandom_range(0, 255)),
			$urandom_range(0, 3) != 0, 8'($urandom_range(0, 255)));
	endfunction

	function automatic cmd_item_t rand_event();
		cmd_item_t c;
		c = rand_enqueue();
		c.op = 2'($urandom_range(1, 3));
		return c;
	endfunction

	initial begin
		cmd_item_t c;
		int n;
		int typed_checks;
		foreach (rings[r, i])
			rings[r][i].st = stqd_pkg::SLOT_FREE;
		for (int r = 0; r < 4; r++) begin
			wptr[r] = 0;
			rptr[r] = 0;
			chan_busy[r] = 0;
		end
		phase = stqd_pkg::PH_ADDR;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: idle events, extremes, bad link, i2c walk, ring overflow
		add_row(mk(stqd_pkg::OP_UART_DONE, 8'h00, 2'd0, 0, 0, 8'h00, 0, 8'h00, 0, 8'h00),
			0, 0, 0, 0);
		add_row(mk(stqd_pkg::OP_I2C_EVENT, 8'hff, 2'd3, 1, 1, 8'hff, 1, 8'hff, 1, 8'hff),
			0, 0, 0, 0);
		add_row(mk(stqd_pkg::OP_ENQUEUE, 8'hff, 2'd3, 1, 1, 8'hff, 1, 8'hff, 1, 8'hff), 1,
			stqd_pkg::ACT_DROPPED, 8'hff, 8'h00);
		add_row(mk(stqd_pkg::OP_ENQUEUE, 8'hff, stqd_pkg::LINK_UART, 0, 0, 8'h00, 0, 8'h00,
			1, 8'hff), 1, stqd_pkg::ACT_UART_SEND, 8'hff, 8'h00);
		add_row(mk(stqd_pkg::OP_ENQUEUE, 8'h00, stqd_pkg::LINK_SPI, 0, 0, 8'h00, 0, 8'h00,
			1, 8'h00), 1, stqd_pkg::ACT_SPI_SEND, 8'h00, 8'h00);
		add_row(mk(stqd_pkg::OP_UART_DONE, 8'h00, 2'd0, 0, 0, 8'h00, 0, 8'h00, 0, 8'h00), 1,
			stqd_pkg::ACT_NOTIFY, 8'h00, 8'hff);
		add_row(mk(stqd_pkg::OP_SPI_DONE, 8'h00, 2'd0, 0, 0, 8'h00, 0, 8'h00, 0, 8'h00), 1,
			stqd_pkg::ACT_NOTIFY, 8'h00, 8'h00);
		add_row(mk(stqd_pkg::OP_ENQUEUE, 8'h5a, stqd_pkg::LINK_I2C, 0, 1, 8'ha4, 1, 8'h3c,
			1, 8'h77), 1, stqd_pkg::ACT_I2C_START, 8'h00, 8'h00);
		add_row(mk(stqd_pkg::OP_ENQUEUE, 8'h11, stqd_pkg::LINK_I2C, 1, 0, 8'hee, 1, 8'hdd,
			0, 8'h01), 0, 0, 0, 0);
		add_row(mk(stqd_pkg::OP_ENQUEUE, 8'h22, stqd_pkg::LINK_UART, 1, 1, 8'h55, 0, 8'haa,
			1, 8'h02), 0, 0, 0, 0);
		for (int i = 0; i < 5; i++)
			add_row(mk(stqd_pkg::OP_I2C_EVENT, 8'h00, 2'd0, 0, 0, 8'h00, 0, 8'h00, 0, 8'h00),
				0, 0, 0, 0);
		for (int i = 0; i < 9; i++)
			add_row(mk(stqd_pkg::OP_ENQUEUE, 8'(i * 29), stqd_pkg::LINK_SPI, 0, 0, 8'h00, 0,
				8'h00, 1, 8'(i)), 0, 0, 0, 0);

		typed_checks = 0;
		foreach (rows[i]) begin
			send_item(rows[i].it, $urandom_range(0, 9));
			if (rows[i].typed) begin
				// the typed result must be the single one this item causes
				if (step_out.size() != 1 || step_out[0].act !== rows[i].want.act
						|| step_out[0].byt !== rows[i].want.byt
						|| step_out[0].tag !== rows[i].want.tag
						|| step_out[0].lst !== rows[i].want.lst)
					report_mismatch("typed row", 8'(i), 8'(step_out.size()));
				typed_checks++;
			end
		end

		// random part: enqueues, slightly outnumbered by events, feeding done and i2c sequences
		n = 0;
		while (n < 345) begin
			if ($urandom_range(0, 99) < 45)
				c = rand_enqueue();
			else
				c = rand_event();
			send_item(c, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
			n++;
		end
		start <= 1'b0;

		while (pending_results.size() != 0 && idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d items accepted, %0d results checked, %0d typed rows",
			accepted_items, checked_results, typed_checks);
		$display("covered drops, all four rings with wrap, and full i2c phase walks");
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: files.f
rtl/stqd_pkg.sv
rtl/stqd_ring.sv
rtl/stqd_datapath.sv
rtl/stqd_ctrl.sv
rtl/serial_transmit_queue_dispatcher_core.sv
rtl/stqd_checker.sv
tb/serial_transmit_queue_dispatcher_core_test.sv
